FILE: src/dcmrc_pkg.sv
package dcmrc_pkg;

   // item codes
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_STEPS = 2'd2;
   localparam logic [1:0] OP_TICK  = 2'd3;

   // command byte that loads a speed
   localparam logic [7:0] CMD_SET = 8'd1;

   // command buffer and status record geometry
   localparam int BufferBytes    = 3;
   localparam logic [7:0] SPEED_LAST_INDEX = 8'd2;

   // status record byte positions
   localparam logic [7:0] ST_DUTY    = 8'd0;
   localparam logic [7:0] ST_FLAGS   = 8'd1;
   localparam logic [7:0] ST_STEP0   = 8'd2;
   localparam logic [7:0] ST_STEP1   = 8'd3;
   localparam logic [7:0] ST_STEP2   = 8'd4;
   localparam logic [7:0] ST_STEP3   = 8'd5;
   localparam logic [7:0] ST_FILL0   = 8'd6;
   localparam logic [7:0] ST_FILL1   = 8'd7;
   localparam logic [7:0] STATUS_FILL = 8'hFF;

   // watchdog
   localparam logic [7:0] TIMEOUT_RESET = 8'd20;
   localparam logic [7:0] WATCHDOG_MAX  = 8'hFF;

   typedef struct packed {
      logic [1:0]        op;
      logic [7:0]        byte_index;
      logic [7:0]        byte_value;
      logic signed [7:0] step_delta;
      logic              stop_one_level;
      logic              stop_two_level;
   } req_type;

   typedef struct packed {
      logic       ack;
      logic [7:0] read_data;
      logic [7:0] drive_duty;
      logic       drive_direction;
      logic       running;
   } rsp_type;

endpackage

FILE: src/dcmrc_req_if.sv
interface dcmrc_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        op;
   logic [7:0]        byte_index;
   logic [7:0]        byte_value;
   logic signed [7:0] step_delta;
   logic              stop_one_level;
   logic              stop_two_level;

   modport source (
      output valid, op, byte_index, byte_value, step_delta, stop_one_level,
             stop_two_level,
      input  ready
   );
   modport sink (
      input  valid, op, byte_index, byte_value, step_delta, stop_one_level,
             stop_two_level,
      output ready
   );
endinterface

FILE: src/dcmrc_rsp_if.sv
interface dcmrc_rsp_if;
   logic       valid;
   logic       ready;
   logic       ack;
   logic [7:0] read_data;
   logic [7:0] drive_duty;
   logic       drive_direction;
   logic       running;

   modport source (
      output valid, ack, read_data, drive_duty, drive_direction, running,
      input  ready
   );
   modport sink (
      input  valid, ack, read_data, drive_duty, drive_direction, running,
      output ready
   );
endinterface

FILE: src/dc_motor_register_controller.sv
// Path: an accepted req beat passes the input register, then the result
//   register, before its rsp beat; the state update happens as the item
//   leaves the input register.
// Throughput: 1 item per cycle while rsp is ready; a stalled rsp holds one
//   result while one more item waits in the input register.
// Reset: synchronous, active high; clears core state, timeout to TIMEOUT_INIT.
module dc_motor_register_controller #(
   parameter logic [7:0] TIMEOUT_INIT = dcmrc_pkg::TIMEOUT_RESET
) (
   input  logic       clock,
   input  logic       reset,
   dcmrc_req_if.sink  req_if,
   dcmrc_rsp_if.source rsp_if,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata
);

   logic               in_valid_ff;
   dcmrc_pkg::req_type in_item_ff;
   dcmrc_pkg::req_type req_item;
   logic               out_valid_ff;
   dcmrc_pkg::rsp_type out_rsp_ff;
   dcmrc_pkg::rsp_type rsp_in;
   logic               advance;
   logic               fire;
   logic               take;

   assign req_item.op             = req_if.op;
   assign req_item.byte_index     = req_if.byte_index;
   assign req_item.byte_value     = req_if.byte_value;
   assign req_item.step_delta     = req_if.step_delta;
   assign req_item.stop_one_level = req_if.stop_one_level;
   assign req_item.stop_two_level = req_if.stop_two_level;

   // pipeline flow
   assign advance       = !out_valid_ff || rsp_if.ready;
   assign fire          = in_valid_ff && advance;
   assign req_if.ready  = !in_valid_ff || advance;
   assign take          = req_if.valid && req_if.ready;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_item_ff <= req_item;
      end
   end

   dcmrc_core #(
      .TIMEOUT_INIT (TIMEOUT_INIT)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .fire      (fire),
      .item      (in_item_ff),
      .rsp_out   (rsp_in)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_rsp_ff <= rsp_in;
      end
   end

   assign rsp_if.valid           = out_valid_ff;
   assign rsp_if.ack             = out_rsp_ff.ack;
   assign rsp_if.read_data       = out_rsp_ff.read_data;
   assign rsp_if.drive_duty      = out_rsp_ff.drive_duty;
   assign rsp_if.drive_direction = out_rsp_ff.drive_direction;
   assign rsp_if.running         = out_rsp_ff.running;

endmodule

FILE: src/dcmrc_core.sv
module dcmrc_core #(
   parameter logic [7:0] TIMEOUT_INIT = dcmrc_pkg::TIMEOUT_RESET
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [7:0]         csr_wdata,
   input  logic               fire,
   input  dcmrc_pkg::req_type item,
   output dcmrc_pkg::rsp_type rsp_out
);

   logic [7:0]  timeout_ff;
   logic [7:0]  cmd_buf_ff [dcmrc_pkg::BufferBytes];
   logic [7:0]  cmd_buf_in [dcmrc_pkg::BufferBytes];
   logic [7:0]  duty_ff, duty_in;
   logic        dir_ff, dir_in;
   logic [1:0]  stop_ff, stop_in;
   logic [31:0] step_ff, step_in;
   logic [7:0]  wd_ff, wd_in;
   logic [7:0]  wd_inc;
   logic [7:0]  read_byte;
   logic        write_ok;
   logic        speed_cmd;
   logic        pass;

   // timeout register
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_INIT;
      end else if (csr_we) begin
         timeout_ff <= csr_wdata;
      end
   end

   // status record byte
   always_comb begin
      case (item.byte_index)
         dcmrc_pkg::ST_DUTY:  read_byte = duty_ff;
         dcmrc_pkg::ST_FLAGS: read_byte = {5'd0, stop_ff, dir_ff};
         dcmrc_pkg::ST_STEP0: read_byte = step_ff[7:0];
         dcmrc_pkg::ST_STEP1: read_byte = step_ff[15:8];
         dcmrc_pkg::ST_STEP2: read_byte = step_ff[23:16];
         dcmrc_pkg::ST_STEP3: read_byte = step_ff[31:24];
         dcmrc_pkg::ST_FILL0,
         dcmrc_pkg::ST_FILL1: read_byte = dcmrc_pkg::STATUS_FILL;
         default:             read_byte = 8'd0;
      endcase
   end

   // next state for one item
   always_comb begin
      write_ok  = item.byte_index < 8'(dcmrc_pkg::BufferBytes);
      speed_cmd = write_ok && (item.byte_index == dcmrc_pkg::SPEED_LAST_INDEX)
                  && (cmd_buf_ff[0] == dcmrc_pkg::CMD_SET);
      wd_inc    = (wd_ff == dcmrc_pkg::WATCHDOG_MAX) ? wd_ff : wd_ff + 8'd1;
      for (int i = 0; i < dcmrc_pkg::BufferBytes; i++) begin
         cmd_buf_in[i] = cmd_buf_ff[i];
      end
      duty_in = duty_ff;
      dir_in  = dir_ff;
      stop_in = stop_ff;
      step_in = step_ff;
      wd_in   = wd_ff;
      rsp_out.ack       = 1'b0;
      rsp_out.read_data = 8'd0;
      unique case (item.op)
         dcmrc_pkg::OP_WRITE: begin
            if (write_ok) begin
               for (int i = 0; i < dcmrc_pkg::BufferBytes; i++) begin
                  if (item.byte_index == 8'(i)) begin
                     cmd_buf_in[i] = item.byte_value;
                  end
               end
               rsp_out.ack = 1'b1;
            end
            // load the speed command on its last byte
            if (speed_cmd) begin
               duty_in = cmd_buf_ff[1];
               dir_in  = item.byte_value[0];
               wd_in   = 8'd0;
            end
         end
         dcmrc_pkg::OP_READ: begin
            rsp_out.read_data = read_byte;
         end
         dcmrc_pkg::OP_STEPS: begin
            step_in = step_ff + {{24{item.step_delta[7]}}, item.step_delta};
         end
         dcmrc_pkg::OP_TICK: begin
            wd_in = wd_inc;
            if (wd_inc > timeout_ff) begin
               duty_in = 8'd0;
            end
            stop_in = {item.stop_two_level, item.stop_one_level};
         end
         default: begin
         end
      endcase
      // gate the drive with the end stop in the commanded direction
      pass = dir_in ? !stop_in[0] : !stop_in[1];
      rsp_out.drive_duty      = pass ? duty_in : 8'd0;
      rsp_out.drive_direction = dir_in;
      rsp_out.running         = duty_in != 8'd0;
   end

   // commit state on each beat
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < dcmrc_pkg::BufferBytes; i++) begin
            cmd_buf_ff[i] <= 8'd0;
         end
         duty_ff <= 8'd0;
         dir_ff  <= 1'b0;
         stop_ff <= 2'd0;
         step_ff <= 32'd0;
         wd_ff   <= 8'd0;
      end else if (fire) begin
         for (int i = 0; i < dcmrc_pkg::BufferBytes; i++) begin
            cmd_buf_ff[i] <= cmd_buf_in[i];
         end
         duty_ff <= duty_in;
         dir_ff  <= dir_in;
         stop_ff <= stop_in;
         step_ff <= step_in;
         wd_ff   <= wd_in;
      end
   end

   a_wd_saturates: assert property (@(posedge clock) disable iff (reset)
      (fire && item.op == dcmrc_pkg::OP_TICK && wd_ff == dcmrc_pkg::WATCHDOG_MAX)
      |=> wd_ff == dcmrc_pkg::WATCHDOG_MAX)
      else $error("watchdog left saturation on tick");

   a_speed_clears_wd: assert property (@(posedge clock) disable iff (reset)
      (fire && item.op == dcmrc_pkg::OP_WRITE && speed_cmd) |=> wd_ff == 8'd0)
      else $error("speed command did not clear watchdog");

   a_refused_write: assert property (@(posedge clock) disable iff (reset)
      (fire && item.op == dcmrc_pkg::OP_WRITE && !write_ok)
      |=> $stable(duty_ff) && $stable(dir_ff) && $stable(wd_ff)
      && $stable(cmd_buf_ff[0]) && $stable(cmd_buf_ff[1]) && $stable(cmd_buf_ff[2]))
      else $error("refused write changed state");

   a_steps_only: assert property (@(posedge clock) disable iff (reset)
      (fire && item.op == dcmrc_pkg::OP_STEPS)
      |=> $stable(duty_ff) && $stable(wd_ff) && $stable(stop_ff))
      else $error("encoder beat changed drive state");

endmodule

FILE: dv/dcmrc_drive_checker.sv
module dcmrc_drive_checker (
   input  logic       clock,
   input  logic       reset,
   dcmrc_req_if       req_mon,
   dcmrc_rsp_if       rsp_mon,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata,
   output int         fault_total,
   output int         awaiting
);

   // shadow copy of the controller registers
   logic [7:0]  cmd_bytes [dcmrc_pkg::BufferBytes];
   logic [7:0]  duty_lvl;
   logic        dir_lvl;
   logic [1:0]  stops;
   logic [31:0] steps;
   logic [7:0]  wdog;
   logic [7:0]  timeout_lvl;

   dcmrc_pkg::rsp_type predicted_drive_q[$];
   dcmrc_pkg::rsp_type want;
   dcmrc_pkg::rsp_type got;
   dcmrc_pkg::req_type seen;
   int                 faults;

   // advance the shadow state by one item and return the drive it produces
   function automatic dcmrc_pkg::rsp_type apply_item(input dcmrc_pkg::req_type item);
      dcmrc_pkg::rsp_type res;
      logic               clear_path;
      res = '0;
      case (item.op)
         dcmrc_pkg::OP_WRITE: begin
            if (item.byte_index < 8'(dcmrc_pkg::BufferBytes)) begin
               cmd_bytes[item.byte_index[1:0]] = item.byte_value;
               res.ack = 1'b1;
               // third byte of a set command loads the speed
               if (item.byte_index == dcmrc_pkg::SPEED_LAST_INDEX &&
                   cmd_bytes[0] == dcmrc_pkg::CMD_SET) begin
                  duty_lvl = cmd_bytes[1];
                  dir_lvl  = cmd_bytes[2][0];
                  wdog     = '0;
               end
            end
         end
         dcmrc_pkg::OP_READ: begin
            case (item.byte_index)
               dcmrc_pkg::ST_DUTY:  res.read_data = duty_lvl;
               dcmrc_pkg::ST_FLAGS: res.read_data = {5'b0, stops, dir_lvl};
               dcmrc_pkg::ST_STEP0: res.read_data = steps[7:0];
               dcmrc_pkg::ST_STEP1: res.read_data = steps[15:8];
               dcmrc_pkg::ST_STEP2: res.read_data = steps[23:16];
               dcmrc_pkg::ST_STEP3: res.read_data = steps[31:24];
               dcmrc_pkg::ST_FILL0,
               dcmrc_pkg::ST_FILL1: res.read_data = dcmrc_pkg::STATUS_FILL;
               default:             res.read_data = '0;
            endcase
         end
         dcmrc_pkg::OP_STEPS: begin
            steps = steps + {{24{item.step_delta[7]}}, item.step_delta};
         end
         default: begin
            // tick: saturate the watchdog, drop duty past the timeout
            if (wdog != dcmrc_pkg::WATCHDOG_MAX) wdog = wdog + 8'd1;
            if (wdog > timeout_lvl) duty_lvl = '0;
            stops = {item.stop_two_level, item.stop_one_level};
         end
      endcase
      // gate the duty with the end stop that blocks the commanded direction
      clear_path = dir_lvl ? !stops[0] : !stops[1];
      res.drive_duty      = clear_path ? duty_lvl : '0;
      res.drive_direction = dir_lvl;
      res.running         = (duty_lvl != '0);
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (cmd_bytes[i]) cmd_bytes[i] = '0;
         duty_lvl    = '0;
         dir_lvl     = 1'b0;
         stops       = '0;
         steps       = '0;
         wdog        = '0;
         timeout_lvl = dcmrc_pkg::TIMEOUT_RESET;
         faults      = 0;
         predicted_drive_q.delete();
      end else begin
         // compare a result beat with the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.ack             = rsp_mon.ack;
            got.read_data       = rsp_mon.read_data;
            got.drive_duty      = rsp_mon.drive_duty;
            got.drive_direction = rsp_mon.drive_direction;
            got.running         = rsp_mon.running;
            if (predicted_drive_q.size() == 0) begin
               faults++;
               if (faults <= 10)
                  $display("rsp beat with nothing pending: %s%0d rd=%02h duty=%02h %s%0d %s%0d",
                           "ack=", got.ack, got.read_data, got.drive_duty,
                           "dir=", got.drive_direction, "run=", got.running);
            end else begin
               want = predicted_drive_q.pop_front();
               if (got.ack !== want.ack || got.read_data !== want.read_data ||
                   got.drive_duty !== want.drive_duty ||
                   got.drive_direction !== want.drive_direction ||
                   got.running !== want.running) begin
                  faults++;
                  if (faults <= 10) begin
                     $display("rsp mismatch: exp ack=%0d rd=%02h duty=%02h dir=%0d run=%0d",
                              want.ack, want.read_data, want.drive_duty,
                              want.drive_direction, want.running);
                     $display("              got ack=%0d rd=%02h duty=%02h dir=%0d run=%0d",
                              got.ack, got.read_data, got.drive_duty,
                              got.drive_direction, got.running);
                  end
               end
            end
         end
         // predict the result of an accepted request beat
         if (req_mon.valid && req_mon.ready) begin
            seen.op             = req_mon.op;
            seen.byte_index     = req_mon.byte_index;
            seen.byte_value     = req_mon.byte_value;
            seen.step_delta     = req_mon.step_delta;
            seen.stop_one_level = req_mon.stop_one_level;
            seen.stop_two_level = req_mon.stop_two_level;
            predicted_drive_q.push_back(apply_item(seen));
         end
         if (csr_we) timeout_lvl = csr_wdata;
      end
      fault_total <= faults;
      awaiting    <= predicted_drive_q.size();
   end

endmodule

FILE: dv/dc_motor_register_controller_tb.sv
module dc_motor_register_controller_tb;

   localparam int QuietLimit = 3000;

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [7:0] csr_wdata;
   int         fault_total;
   int         awaiting;
   int         send_idle_pct;
   int         recv_stall_pct;
   int         items_sent;
   int         quiet_cycles;

   dcmrc_req_if req_ch ();
   dcmrc_rsp_if rsp_ch ();

   dc_motor_register_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   dcmrc_drive_checker drive_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .fault_total (fault_total),
      .awaiting    (awaiting)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // stall the result channel at random
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // end the run if no beat moves for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QuietLimit) begin
         $display("dc_motor_register_controller_tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic dcmrc_pkg::req_type req_of(input logic [1:0] op,
                                                 input logic [7:0] idx,
                                                 input logic [7:0] val,
                                                 input logic [7:0] delta,
                                                 input logic s1, input logic s2);
      dcmrc_pkg::req_type item;
      item.op             = op;
      item.byte_index     = idx;
      item.byte_value     = val;
      item.step_delta     = delta;
      item.stop_one_level = s1;
      item.stop_two_level = s2;
      return item;
   endfunction

   function automatic dcmrc_pkg::req_type random_item();
      return req_of(2'($urandom_range(3)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)));
   endfunction

   // present one request beat, with random idle cycles ahead of it
   task automatic send(input dcmrc_pkg::req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.op             <= item.op;
      req_ch.byte_index     <= item.byte_index;
      req_ch.byte_value     <= item.byte_value;
      req_ch.step_delta     <= item.step_delta;
      req_ch.stop_one_level <= item.stop_one_level;
      req_ch.stop_two_level <= item.stop_two_level;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   task automatic send_op(input logic [1:0] op, input logic [7:0] idx, input logic [7:0] val);
      dcmrc_pkg::req_type item;
      item            = random_item();
      item.op         = op;
      item.byte_index = idx;
      item.byte_value = val;
      send(item);
   endtask

   task automatic send_speed(input logic [7:0] duty, input logic [7:0] dir_byte);
      send_op(dcmrc_pkg::OP_WRITE, 8'd0, dcmrc_pkg::CMD_SET);
      send_op(dcmrc_pkg::OP_WRITE, 8'd1, duty);
      send_op(dcmrc_pkg::OP_WRITE, dcmrc_pkg::SPEED_LAST_INDEX, dir_byte);
   endtask

   task automatic send_tick(input logic s1, input logic s2);
      dcmrc_pkg::req_type item;
      item                = random_item();
      item.op             = dcmrc_pkg::OP_TICK;
      item.stop_one_level = s1;
      item.stop_two_level = s2;
      send(item);
   endtask

   // hold until every predicted result has arrived, then let the pipe settle
   task automatic drain(input int tail);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (awaiting != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic set_timeout(input logic [7:0] value);
      drain(4);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic random_burst();
      dcmrc_pkg::req_type item;
      int                 pick;
      int                 n;
      pick = $urandom_range(99);
      if (pick < 30) begin
         // well-formed speed command with random content
         n = $urandom_range(9);
         send_speed(n == 0 ? 8'd0 : n == 1 ? 8'hFF : 8'($urandom_range(255)),
                    8'($urandom_range(255)));
      end else if (pick < 40) begin
         // broken command: stray command byte or out-of-order writes
         send_op(dcmrc_pkg::OP_WRITE, 8'($urandom_range(3)), 8'($urandom_range(3)));
         send_op(dcmrc_pkg::OP_WRITE, dcmrc_pkg::SPEED_LAST_INDEX, 8'($urandom_range(255)));
      end else if (pick < 60) begin
         send_op(dcmrc_pkg::OP_READ, ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                              : 8'($urandom_range(7)), 8'd0);
      end else if (pick < 72) begin
         item    = random_item();
         item.op = dcmrc_pkg::OP_STEPS;
         send(item);
      end else if (pick < 90) begin
         send_tick($urandom_range(3) == 0, $urandom_range(3) == 0);
      end else if (pick < 95) begin
         n = $urandom_range(40, 1);
         repeat (n) send_tick($urandom_range(7) == 0, $urandom_range(7) == 0);
      end else begin
         send(random_item());
      end
   endtask

   initial begin
      int phase_end;
      reset          <= 1'b1;
      csr_we         <= 1'b0;
      csr_wdata      <= '0;
      req_ch.valid   <= 1'b0;
      req_ch.op      <= dcmrc_pkg::OP_WRITE;
      req_ch.byte_index     <= '0;
      req_ch.byte_value     <= '0;
      req_ch.step_delta     <= '0;
      req_ch.stop_one_level <= 1'b0;
      req_ch.stop_two_level <= 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      items_sent     = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // step count wraps below zero, then read the step and fill bytes and past the record
      send(req_of(dcmrc_pkg::OP_STEPS, 8'd0, 8'd0, 8'h80, 1'b0, 1'b0));
      send(req_of(dcmrc_pkg::OP_STEPS, 8'd0, 8'd0, 8'h7F, 1'b0, 1'b0));
      send(req_of(dcmrc_pkg::OP_READ, dcmrc_pkg::ST_STEP0, 8'd0, 8'd0, 1'b0, 1'b0));
      send(req_of(dcmrc_pkg::OP_READ, dcmrc_pkg::ST_STEP1, 8'd0, 8'd0, 1'b0, 1'b0));
      send(req_of(dcmrc_pkg::OP_READ, dcmrc_pkg::ST_STEP2, 8'd0, 8'd0, 1'b0, 1'b0));
      send(req_of(dcmrc_pkg::OP_READ, dcmrc_pkg::ST_STEP3, 8'd0, 8'd0, 1'b0, 1'b0));
      send(req_of(dcmrc_pkg::OP_READ, dcmrc_pkg::ST_FILL0, 8'd0, 8'd0, 1'b0, 1'b0));
      send(req_of(dcmrc_pkg::OP_READ, dcmrc_pkg::ST_FILL1, 8'd0, 8'd0, 1'b0, 1'b0));
      send(req_of(dcmrc_pkg::OP_READ, 8'd8, 8'd0, 8'd0, 1'b0, 1'b0));
      send(req_of(dcmrc_pkg::OP_READ, 8'hFF, 8'd0, 8'd0, 1'b0, 1'b0));
      // full duty forward, then each end stop in turn
      send_speed(8'hFF, 8'h01);
      send(req_of(dcmrc_pkg::OP_READ, dcmrc_pkg::ST_DUTY, 8'd0, 8'd0, 1'b0, 1'b0));
      send(req_of(dcmrc_pkg::OP_READ, dcmrc_pkg::ST_FLAGS, 8'd0, 8'd0, 1'b0, 1'b0));
      send(req_of(dcmrc_pkg::OP_TICK, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0));
      send(req_of(dcmrc_pkg::OP_TICK, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1));
      send(req_of(dcmrc_pkg::OP_READ, dcmrc_pkg::ST_FLAGS, 8'd0, 8'd0, 1'b0, 1'b0));
      // writes past the buffer are refused
      send(req_of(dcmrc_pkg::OP_WRITE, 8'd3, 8'hFF, 8'd0, 1'b0, 1'b0));
      send(req_of(dcmrc_pkg::OP_WRITE, 8'hFF, 8'hFF, 8'd0, 1'b0, 1'b0));
      // last byte without the set command loads nothing
      send(req_of(dcmrc_pkg::OP_WRITE, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0));
      send(req_of(dcmrc_pkg::OP_WRITE, dcmrc_pkg::SPEED_LAST_INDEX, 8'd0, 8'd0, 1'b0, 1'b0));
      // reverse at the old duty, blocked by end stop 2
      send(req_of(dcmrc_pkg::OP_WRITE, 8'd0, dcmrc_pkg::CMD_SET, 8'd0, 1'b0, 1'b0));
      send(req_of(dcmrc_pkg::OP_WRITE, dcmrc_pkg::SPEED_LAST_INDEX, 8'hFE, 8'd0, 1'b0, 1'b0));
      send(req_of(dcmrc_pkg::OP_TICK, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1));

      // random phases across timeout settings and idle patterns
      for (int p = 0; p < 6; p++) begin
         case (p)
            1: set_timeout(8'd1);
            2: set_timeout(8'hFF);
            3: set_timeout(8'd0);
            4: set_timeout(8'($urandom_range(254, 2)));
            5: set_timeout(8'd3);
            default: ;
         endcase
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
            default: begin send_idle_pct = 10; recv_stall_pct = 10; end
         endcase
         // at the top timeout run the watchdog into saturation
         if (p == 2) begin
            send_speed(8'd200, 8'd0);
            repeat (270) send_tick(1'b0, 1'b0);
            send_op(dcmrc_pkg::OP_READ, dcmrc_pkg::ST_DUTY, 8'd0);
         end
         phase_end = items_sent + 150;
         while (items_sent < phase_end) random_burst();
      end

      drain(8);
      if (fault_total == 0 && awaiting == 0)
         $display("dc_motor_register_controller_tb: done, clean");
      else
         $display("dc_motor_register_controller_tb: done, errors");
      $finish;
   end

endmodule
